// File: rtl/kmst_pkg.sv
// Shared types and constants for the matrix Kruskal spanning tree block.
package kmst_pkg;

    localparam int NODE_W   = 6;
    localparam int WEIGHT_W = 14;
    localparam int STATUS_W = 2;

    localparam logic [WEIGHT_W-1:0] NO_EDGE = WEIGHT_W'(10000);

    localparam logic [STATUS_W-1:0] STATUS_TREE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SINGLE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DISCON = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_FIND_A,
        ST_FIND_B,
        ST_EMIT
    } kmst_state_t;

endpackage

// File: rtl/kmst_weight_ram.sv
// Weight matrix storage: one write port, one registered read port.
module kmst_weight_ram
    import kmst_pkg::*;
#(
    parameter int AW = 10
) (
    input  logic                aclk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  logic [WEIGHT_W-1:0] wdata,
    input  logic [AW-1:0]       raddr,
    output logic [WEIGHT_W-1:0] rdata
);

    logic [WEIGHT_W-1:0] mem [0:(2**AW)-1];
    logic [WEIGHT_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/kmst_forest.sv
// Union-find parent table; every node points to itself after reset or clear.
module kmst_forest
    import kmst_pkg::*;
#(
    parameter int MAX_NODES = 32,
    parameter int AW        = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          clear,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [AW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [AW-1:0] rdata
);

    logic [AW-1:0] parent_reg [0:MAX_NODES-1];

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_NODES; k++) begin
            if (!aresetn || clear) begin
                parent_reg[k] <= AW'(k);
            end else if (we && (waddr == AW'(k))) begin
                parent_reg[k] <= wdata;
            end
        end
    end

    assign rdata = parent_reg[raddr];

endmodule

// File: rtl/matrix_kruskal_spanning_tree.sv
// Top level: edge loading, Kruskal sequencer and result output register.
//
// Edges are accepted one per cycle while idle into a symmetric weight matrix
// held as an upper-triangle RAM. The transaction with tlast set stores its edge
// and starts a run: each round scans all (i,j) pairs with i<j<n, one RAM read
// per cycle through one shared comparator, then drains the last read and
// decides, then walks both endpoints to their roots one parent step per cycle
// and, for a kept edge, waits in the emit state until the output register is
// free. There is one round per edge taken out of the matrix, so at least n-1
// rounds for a connected graph and as many as it needs otherwise; the input is
// not ready meanwhile. After reset and after every run the matrix is swept back
// to "no edge", one entry per cycle over all 2**(2*clog2(MAX_NODES)) entries
// (1024 by default); configuration writes are taken at any time.
module matrix_kruskal_spanning_tree
    import kmst_pkg::*;
#(
    parameter int MAX_NODES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: active_nodes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    // s_tdata: node_a[5:0], node_b[11:6], weight[25:12]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,  // last_edge
    // m_tdata: edge_from[5:0], edge_to[11:6]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic [1:0]  m_tuser,  // status
    output logic        m_tlast   // last_result
);

    localparam int AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int RAW = 2 * AW;
    localparam logic [NODE_W:0] MAX_N = (NODE_W+1)'(MAX_NODES);

    kmst_state_t state_reg, state_next;

    logic [5:0]          active_nodes_reg;
    logic [AW-1:0]       n_last_reg, n_last_next;
    logic [AW-1:0]       ri_reg, ri_next, cj_reg, cj_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [AW-1:0]       pend_i_reg, pend_i_next, pend_j_reg, pend_j_next;
    logic [WEIGHT_W-1:0] best_reg, best_next;
    logic [AW-1:0]       bi_reg, bi_next, bj_reg, bj_next;
    logic [AW-1:0]       x_reg, x_next, ra_reg, ra_next;
    logic [AW-1:0]       chosen_reg, chosen_next;
    logic [RAW-1:0]      clr_reg, clr_next;
    logic [NODE_W-1:0]   res_from_reg, res_from_next, res_to_reg, res_to_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                res_last_reg, res_last_next;

    logic                m_valid_reg;
    logic [NODE_W-1:0]   m_from_reg, m_to_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic                m_last_reg;

    // input fields
    logic [NODE_W-1:0]   node_a, node_b, node_lo, node_hi, lo_m1, hi_m1;
    logic [WEIGHT_W-1:0] weight, weight_clamp;
    logic                in_accept, edge_ok;

    // n handling
    logic [AW-1:0]       cfg_n_last;

    // RAM and forest ports
    logic                ram_we;
    logic [RAW-1:0]      ram_waddr, ram_raddr;
    logic [WEIGHT_W-1:0] ram_wdata, ram_rdata;
    logic                fr_clear, fr_we;
    logic [AW-1:0]       fr_waddr, fr_wdata, fr_rdata;

    logic                out_free, scan_hit, scan_last, at_root;
    logic                scan_start, tree_done;

    assign node_a    = s_tdata[5:0];
    assign node_b    = s_tdata[11:6];
    assign weight    = s_tdata[25:12];
    assign in_accept = s_tvalid && s_tready;

    assign edge_ok = (node_a != '0) && ({1'b0, node_a} <= MAX_N)
                  && (node_b != '0) && ({1'b0, node_b} <= MAX_N)
                  && (node_a != node_b);
    assign node_lo      = (node_a < node_b) ? node_a : node_b;
    assign node_hi      = (node_a < node_b) ? node_b : node_a;
    assign lo_m1        = node_lo - NODE_W'(1);
    assign hi_m1        = node_hi - NODE_W'(1);
    assign weight_clamp = (weight >= NO_EDGE) ? NO_EDGE : weight;

    // 0 counts as one node, anything above MAX_NODES as MAX_NODES
    always_comb begin
        priority if (active_nodes_reg == '0) begin
            cfg_n_last = '0;
        end else if ({1'b0, active_nodes_reg} > MAX_N) begin
            cfg_n_last = AW'(MAX_NODES - 1);
        end else begin
            cfg_n_last = AW'(active_nodes_reg - 6'd1);
        end
    end

    assign out_free  = !m_valid_reg || m_tready;
    assign scan_hit  = pend_valid_reg && (ram_rdata < best_reg);
    assign scan_last = (ri_reg == n_last_reg - AW'(1)) && (cj_reg == n_last_reg);
    assign at_root   = (fr_rdata == x_reg);
    assign tree_done = ({1'b0, chosen_reg} + (AW+1)'(1)) == {1'b0, n_last_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (&clr_reg) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_accept && s_tlast) begin
                    state_next = (cfg_n_last == '0) ? ST_EMIT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) state_next = ST_SCAN_END;
            end
            ST_SCAN_END: state_next = ST_DECIDE;
            ST_DECIDE: begin
                state_next = (best_reg == NO_EDGE) ? ST_EMIT : ST_FIND_A;
            end
            ST_FIND_A: begin
                if (at_root) state_next = ST_FIND_B;
            end
            ST_FIND_B: begin
                if (at_root) state_next = (ra_reg != x_reg) ? ST_EMIT : ST_SCAN;
            end
            ST_EMIT: begin
                if (out_free) state_next = res_last_reg ? ST_CLEAR : ST_SCAN;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    assign scan_start = (state_next == ST_SCAN) && (state_reg != ST_SCAN);

    // datapath and port controls
    always_comb begin
        n_last_next     = n_last_reg;
        ri_next         = ri_reg;
        cj_next         = cj_reg;
        pend_valid_next = 1'b0;
        pend_i_next     = ri_reg;
        pend_j_next     = cj_reg;
        best_next       = best_reg;
        bi_next         = bi_reg;
        bj_next         = bj_reg;
        x_next          = x_reg;
        ra_next         = ra_reg;
        chosen_next     = chosen_reg;
        clr_next        = clr_reg;
        res_from_next   = res_from_reg;
        res_to_next     = res_to_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = {lo_m1[AW-1:0], hi_m1[AW-1:0]};
        ram_wdata       = weight_clamp;
        ram_raddr       = {ri_reg, cj_reg};
        fr_clear        = 1'b0;
        fr_we           = 1'b0;
        fr_waddr        = ra_reg;
        fr_wdata        = x_reg;

        // shared comparator: running minimum over the pending read
        if (scan_hit) begin
            best_next = ram_rdata;
            bi_next   = pend_i_reg;
            bj_next   = pend_j_reg;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we      = 1'b1;
                ram_waddr   = clr_reg;
                ram_wdata   = NO_EDGE;
                clr_next    = clr_reg + RAW'(1);
                fr_clear    = 1'b1;
                chosen_next = '0;
            end
            ST_IDLE: begin
                ram_we      = in_accept && edge_ok;
                n_last_next = cfg_n_last;
                res_from_next   = '0;
                res_to_next     = '0;
                res_status_next = STATUS_SINGLE;
                res_last_next   = 1'b1;
            end
            ST_SCAN: begin
                pend_valid_next = 1'b1;
                if (cj_reg == n_last_reg) begin
                    ri_next = ri_reg + AW'(1);
                    cj_next = ri_reg + AW'(2);
                end else begin
                    cj_next = cj_reg + AW'(1);
                end
            end
            ST_SCAN_END: begin
            end
            ST_DECIDE: begin
                ram_we    = (best_reg != NO_EDGE);
                ram_waddr = {bi_reg, bj_reg};
                ram_wdata = NO_EDGE;
                x_next    = bi_reg;
                res_from_next   = '0;
                res_to_next     = '0;
                res_status_next = STATUS_DISCON;
                res_last_next   = 1'b1;
            end
            ST_FIND_A: begin
                if (at_root) begin
                    ra_next = x_reg;
                    x_next  = bj_reg;
                end else begin
                    x_next = fr_rdata;
                end
            end
            ST_FIND_B: begin
                if (at_root) begin
                    if (ra_reg != x_reg) begin
                        fr_we           = 1'b1;
                        chosen_next     = chosen_reg + AW'(1);
                        res_from_next   = NODE_W'(bi_reg) + NODE_W'(1);
                        res_to_next     = NODE_W'(bj_reg) + NODE_W'(1);
                        res_status_next = STATUS_TREE;
                        res_last_next   = tree_done;
                    end
                end else begin
                    x_next = fr_rdata;
                end
            end
            ST_EMIT: begin
                clr_next = '0;
            end
            default: begin
            end
        endcase

        if (scan_start) begin
            ri_next         = '0;
            cj_next         = AW'(1);
            pend_valid_next = 1'b0;
            best_next       = NO_EDGE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            active_nodes_reg <= 6'd32;
            clr_reg          <= '0;
            pend_valid_reg   <= 1'b0;
            chosen_reg       <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            pend_valid_reg <= pend_valid_next;
            chosen_reg     <= chosen_next;
            if (cfg_valid) begin
                active_nodes_reg <= cfg_data;
            end
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_last_reg     <= n_last_next;
        ri_reg         <= ri_next;
        cj_reg         <= cj_next;
        pend_i_reg     <= pend_i_next;
        pend_j_reg     <= pend_j_next;
        best_reg       <= best_next;
        bi_reg         <= bi_next;
        bj_reg         <= bj_next;
        x_reg          <= x_next;
        ra_reg         <= ra_next;
        res_from_reg   <= res_from_next;
        res_to_reg     <= res_to_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
        if (state_reg == ST_EMIT && out_free) begin
            m_from_reg   <= res_from_reg;
            m_to_reg     <= res_to_reg;
            m_status_reg <= res_status_reg;
            m_last_reg   <= res_last_reg;
        end
    end

    kmst_weight_ram #(
        .AW(RAW)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    kmst_forest #(
        .MAX_NODES(MAX_NODES),
        .AW       (AW)
    ) u_forest (
        .aclk   (aclk),
        .aresetn(aresetn),
        .clear  (fr_clear),
        .we     (fr_we),
        .waddr  (fr_waddr),
        .wdata  (fr_wdata),
        .raddr  (x_reg),
        .rdata  (fr_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {4'b0000, m_to_reg, m_from_reg};
    assign m_tuser   = m_status_reg;
    assign m_tlast   = m_last_reg;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the matrix Kruskal spanning tree block.
module tb_top;
    import kmst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NMAX = 32;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [5:0]  node_a;
        logic [5:0]  node_b;
        logic [13:0] weight;
        logic        last_edge;
    } edge_item_t;

    typedef struct packed {
        logic [5:0] edge_from;
        logic [5:0] edge_to;
        logic [1:0] status;
        logic       last_result;
    } tree_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    matrix_kruskal_spanning_tree #(.MAX_NODES(NMAX)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #1 aclk = ~aclk;

    // predictor state
    logic [13:0]  weight_mat [NMAX][NMAX];
    logic [5:0]   parent [NMAX];
    int           kept_edges;
    logic [5:0]   node_count;
    tree_result_t tree_expected [$];
    edge_item_t   edge_queue [$];
    int           errors = 0;
    int           cycles = 0;
    logic         edge_taken = 1'b0;

    function automatic void clear_graph();
        for (int i = 0; i < NMAX; i++) begin
            for (int j = 0; j < NMAX; j++) weight_mat[i][j] = NO_EDGE;
            parent[i] = 6'(i);
        end
        kept_edges = 0;
    endfunction

    function automatic int root_of(int x);
        int p;
        for (int k = 0; k < NMAX; k++) begin
            p = parent[x];
            if (p == x || p >= NMAX) break;
            x = p;
        end
        return x;
    endfunction

    function automatic void add_result(int f, int t, logic [1:0] st, bit lst);
        tree_result_t r;
        r.edge_from = 6'(f);
        r.edge_to = 6'(t);
        r.status = st;
        r.last_result = lst;
        tree_expected.push_back(r);
    endfunction

    // store one edge; on the final edge build the expected spanning tree
    function automatic void apply_edge(edge_item_t it);
        int n, bi, bj, ri, rj;
        logic [13:0] best, wv;
        if (it.node_a >= 1 && it.node_a <= NMAX && it.node_b >= 1 && it.node_b <= NMAX &&
            it.node_a != it.node_b) begin
            wv = (it.weight >= NO_EDGE) ? NO_EDGE : it.weight;
            weight_mat[it.node_a-1][it.node_b-1] = wv;
            weight_mat[it.node_b-1][it.node_a-1] = wv;
        end
        if (!it.last_edge) return;
        n = node_count;
        if (n < 1) n = 1;
        if (n > NMAX) n = NMAX;
        if (n == 1) begin
            add_result(0, 0, STATUS_SINGLE, 1'b1);
            clear_graph();
            return;
        end
        while (kept_edges < n - 1) begin
            best = NO_EDGE;
            bi = 0;
            bj = 0;
            for (int i = 0; i < n; i++)
                for (int j = i + 1; j < n; j++)
                    if (weight_mat[i][j] < best) begin
                        best = weight_mat[i][j];
                        bi = i;
                        bj = j;
                    end
            if (best == NO_EDGE) begin
                add_result(0, 0, STATUS_DISCON, 1'b1);
                break;
            end
            weight_mat[bi][bj] = NO_EDGE;
            weight_mat[bj][bi] = NO_EDGE;
            ri = root_of(bi);
            rj = root_of(bj);
            if (ri != rj) begin
                parent[ri] = 6'(rj);
                kept_edges++;
                add_result(bi + 1, bj + 1, STATUS_TREE, kept_edges == n - 1);
            end
        end
        clear_graph();
    endfunction

    // acceptance, prediction and result checking on the rising edge
    always @(posedge aclk) begin
        tree_result_t got, want;
        edge_taken <= aresetn && s_tvalid && s_tready;
        if (!aresetn) begin
            clear_graph();
            node_count = 6'd32;
        end else begin
            if (cfg_valid && cfg_ready) node_count = cfg_data;
            if (s_tvalid && s_tready)
                apply_edge({s_tdata[5:0], s_tdata[11:6], s_tdata[25:12], s_tlast});
            if (m_tvalid && m_tready) begin
                got = {m_tdata[5:0], m_tdata[11:6], m_tuser, m_tlast};
                if (tree_expected.size() == 0) begin
                    $display("%0t: unexpected result %h", $realtime, got);
                    errors++;
                end else begin
                    want = tree_expected.pop_front();
                    if (got.edge_from !== want.edge_from) begin
                        $display("%0t: edge_from expected %0d actual %0d",
                                 $realtime, want.edge_from, got.edge_from);
                        errors++;
                    end
                    if (got.edge_to !== want.edge_to) begin
                        $display("%0t: edge_to expected %0d actual %0d",
                                 $realtime, want.edge_to, got.edge_to);
                        errors++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, want.status, got.status);
                        errors++;
                    end
                    if (got.last_result !== want.last_result) begin
                        $display("%0t: last_result expected %0d actual %0d",
                                 $realtime, want.last_result, got.last_result);
                        errors++;
                    end
                end
            end
        end
    end

    // edge driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge aclk) begin
        edge_item_t it;
        if (aresetn && (!s_tvalid || edge_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (edge_queue.size() > 0) begin
                it = edge_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {6'd0, it.weight, it.node_b, it.node_a};
                s_tlast <= it.last_edge;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: own stall pattern, one long hold-off on a result that
    // arrives while further edges are still waiting to be sent
    int stall_left = 0;
    bit long_hold_done = 0;
    int ready_mode = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!long_hold_done && m_tvalid && edge_queue.size() > 0) begin
                long_hold_done = 1;
                stall_left = 600;
                m_tready <= 1'b0;
            end else begin
                if ($urandom_range(0, 63) == 0) ready_mode = $urandom_range(0, 2);
                case (ready_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic wait_idle();
        while (edge_queue.size() > 0 || s_tvalid || tree_expected.size() > 0)
            @(posedge aclk);
    endtask

    task automatic write_nodes(logic [5:0] v);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void push_edge(int a, int b, int w, bit lst);
        edge_item_t it;
        it.node_a = 6'(a);
        it.node_b = 6'(b);
        it.weight = 14'(w);
        it.last_edge = lst;
        edge_queue.push_back(it);
    endfunction

    // one problem on n nodes: mostly a connected graph with random extras
    function automatic int queue_problem(int n);
        int cnt, extra, perm [NMAX], tmp, k, wmax;
        cnt = 0;
        wmax = ($urandom_range(0, 3) == 0) ? 16383 : 15;
        for (int i = 0; i < n; i++) perm[i] = i + 1;
        for (int i = n - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[k];
            perm[k] = tmp;
        end
        if ($urandom_range(0, 4) != 0)
            for (int i = 1; i < n; i++) begin
                if ($urandom_range(0, 19) == 0) continue;  // sometimes leave a gap
                push_edge(perm[$urandom_range(0, i - 1)], perm[i],
                          $urandom_range(0, wmax), 0);
                cnt++;
            end
        extra = $urandom_range(0, (n > 8) ? 10 : n + 2);
        for (int e = 0; e < extra; e++) begin
            if ($urandom_range(0, 9) == 0)
                push_edge($urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 16383), 0);
            else
                push_edge($urandom_range(1, n), $urandom_range(1, n),
                          $urandom_range(0, wmax), 0);
            cnt++;
        end
        push_edge($urandom_range(1, n), $urandom_range(1, n), $urandom_range(0, wmax), 1);
        return cnt + 1;
    endfunction

    initial begin
        int sent, n;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: range checks, self loop, overwrite, absent weight, disconnect
        push_edge(1, 2, 0, 0);
        push_edge(2, 3, 9999, 0);
        push_edge(0, 5, 7, 0);
        push_edge(33, 1, 7, 0);
        push_edge(63, 63, 16383, 0);
        push_edge(4, 4, 1, 0);
        push_edge(3, 4, 5, 0);
        push_edge(3, 4, 10000, 0);       // removes the pair again
        push_edge(1, 2, 3, 0);           // overwrite
        push_edge(31, 32, 16383, 1);
        write_nodes(6'd1);
        push_edge(1, 2, 4, 1);           // single node
        write_nodes(6'd0);
        push_edge(5, 6, 4, 1);
        write_nodes(6'd63);
        push_edge(2, 1, 1, 1);           // clamped to 32: disconnected
        write_nodes(6'd3);
        push_edge(1, 2, 7, 0);
        push_edge(2, 3, 7, 0);
        push_edge(1, 3, 7, 0);           // equal weights, row-major tie break
        push_edge(3, 9, 1, 1);           // beyond the active nodes
        write_nodes(6'd2);
        push_edge(2, 1, 0, 1);
        sent = 22;

        while (sent < 400) begin
            case ($urandom_range(0, 19))
                0: n = 32;
                1: n = $urandom_range(0, 1);
                2: n = 63;
                3, 4, 5: n = $urandom_range(9, 20);
                default: n = $urandom_range(2, 8);
            endcase
            write_nodes(6'(n));
            if (n > NMAX) n = NMAX;
            if (n < 1) n = 1;
            repeat ($urandom_range(1, 3)) sent += queue_problem(n);
        end

        wait_idle();
        repeat (3000) @(posedge aclk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
